// ===== rtl/core/date_offset_and_difference_core_macros.svh =====
// Assertion macros for the date offset and difference core.
// Used by the top level only; depends on nothing else.
`ifndef DATE_OFFSET_AND_DIFFERENCE_CORE_MACROS_SVH
`define DATE_OFFSET_AND_DIFFERENCE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define DOAD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// The condition must never be true outside reset.
`define DOAD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define DOAD_ASSERT(lbl, clk, rst_n, prop)
`define DOAD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/doad_pkg.sv =====
// Shared types, codes and calendar helpers of the date offset and difference core.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none
package doad_pkg;

  // Mode codes of an input word.
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_SUB  = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Order codes of a result word.
  localparam logic [1:0] ORD_EQUAL  = 2'd0;
  localparam logic [1:0] ORD_BEFORE = 2'd1;
  localparam logic [1:0] ORD_AFTER  = 2'd2;

  // floor(x / 100) equals (x * RECIP_100) >> RECIP_SHIFT for every x below 2**14.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [21:0] DIFF_MAX = 22'h3FFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIVQ,
    ST_DIVR,
    ST_DOY,
    ST_SQ100,
    ST_SQ400,
    ST_SER,
    ST_WALK,
    ST_CMP,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIVQ,
    OP_DIVR,
    OP_DOY,
    OP_SQ100,
    OP_SQ400,
    OP_SER,
    OP_WALK,
    OP_CMP,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e  op;
    logic side;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       walk_done;
  } status_t;

  // Days before the first of a month in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      default: s = 9'd334;
    endcase
    return s;
  endfunction

  // Leap rule from the year taken modulo 400.
  function automatic logic leap_of(input logic [8:0] r);
    logic l;
    l = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/date_offset_and_difference_core.sv =====
// Gregorian date calculator. A word on the input stream either moves date A by
// delta_days (mode 0 adds, mode 1 subtracts) or compares dates A and B (mode 2),
// and gives exactly one result word; a mode 3 word is taken and dropped without
// a result. Offsets walk one calendar year per clock. The shared divide-by-100
// multiplier serves both dates of a comparison in turn. The block handles one
// word at a time. A finished result waits in its output register, so the next
// input word is taken while the previous result is still pending. A result that
// cannot leave its register holds the next result back. Years outside
// 1..MAX_YEAR set out_of_range; an offset result then saturates its date.
`default_nettype none
`include "date_offset_and_difference_core_macros.svh"
module date_offset_and_difference_core
  import doad_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0: mode[1:0], day_a[6:2], month_a[10:7], year_a[24:11],
  // day_b[29:25], month_b[33:30], year_b[47:34], delta_days[63:48].
  input  wire logic [63:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // Fields from bit 0: day_out[4:0], month_out[8:5], year_out[22:9],
  // day_difference[44:23], order[46:45], out_of_range[47].
  output logic      [47:0] m_axis_tdata_o
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences each word and owns both handshakes.
  doad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the operands, walks years and forms serial day numbers.
  doad_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

  // Handshake and result-load events watched by the checks below.
  logic       in_word_taken;
  logic       result_load;
  logic [1:0] res_order;

  assign in_word_taken = s_axis_tvalid_i && s_axis_tready_o;
  assign result_load   = (cmd.op == OP_CMP) || (cmd.op == OP_FIN);
  assign res_order     = m_axis_tdata_o[46:45];

  // After a word is taken, no second word is taken in the following cycle.
  `DOAD_ASSERT(a_no_back_to_back, clk_i, rst_ni, in_word_taken |=> !s_axis_tready_o)
  // A result only appears after the datapath has just loaded it.
  `DOAD_ASSERT(a_result_loaded, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(result_load))
  // A valid result never carries the unused order code.
  `DOAD_ASSERT_NEVER(a_order_code, clk_i, rst_ni, m_axis_tvalid_o && (res_order > ORD_AFTER))

endmodule
`default_nettype wire

// ===== rtl/core/doad_ctrl.sv =====
// Sequencer of the date offset and difference core.
// Depends on doad_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none
module doad_ctrl
  import doad_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   side_q, side_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    side_d     = side_q;
    cmd_o.op   = OP_NONE;
    cmd_o.side = side_q;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          side_d   = 1'b0;
          state_d  = ST_START;
        end
      end
      ST_START: begin
        // A word with no meaning gives no result.
        if (status_i.mode == MODE_NONE) state_d = ST_IDLE;
        else                            state_d = ST_DIVQ;
      end
      ST_DIVQ: begin
        cmd_o.op = OP_DIVQ;
        state_d  = ST_DIVR;
      end
      ST_DIVR: begin
        cmd_o.op = OP_DIVR;
        state_d  = ST_DOY;
      end
      ST_DOY: begin
        cmd_o.op = OP_DOY;
        if (status_i.mode == MODE_DIFF) state_d = ST_SQ100;
        else                            state_d = ST_WALK;
      end
      ST_SQ100: begin
        cmd_o.op = OP_SQ100;
        state_d  = ST_SQ400;
      end
      ST_SQ400: begin
        cmd_o.op = OP_SQ400;
        state_d  = ST_SER;
      end
      ST_SER: begin
        cmd_o.op = OP_SER;
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = ST_DIVQ;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_WALK: begin
        if (status_i.walk_done) state_d = ST_FIN;
        else                    cmd_o.op = OP_WALK;
      end
      ST_CMP: begin
        if (out_free) begin
          cmd_o.op = OP_CMP;
          state_d  = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.op = OP_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((cmd_o.op == OP_CMP) || (cmd_o.op == OP_FIN)) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/doad_datapath.sv =====
// Datapath of the date offset and difference core: operands, year walker,
// serial day unit with a shared reciprocal multiplier, and the result register.
// Depends on doad_pkg; commanded by doad_ctrl.
`default_nettype none
module doad_datapath
  import doad_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic        clk_i,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire logic [63:0] in_data_i,
  output logic      [47:0] out_data_o
);

  localparam logic signed [17:0] MaxY = 18'(MAX_YEAR);

  // Operands.
  logic [1:0]  mode_q;
  logic [4:0]  day_a_q, day_b_q;
  logic [3:0]  month_a_q, month_b_q;
  logic [13:0] year_a_q, year_b_q;
  logic [15:0] delta_q;

  // Working registers.
  logic [7:0]         qy_q, q100_q, q400_q;
  logic [8:0]         r400_q, r_q;
  logic signed [17:0] doy_q;
  logic signed [16:0] y_q;
  logic signed [23:0] sa_q, sb_q;
  logic               oor_q;

  // Result register.
  logic [4:0]  day_out_q;
  logic [3:0]  month_out_q;
  logic [13:0] year_out_q;
  logic [21:0] diff_q;
  logic [1:0]  order_q;
  logic        res_oor_q;

  logic [4:0]  day_sel;
  logic [3:0]  mon_sel, m_cl;
  logic [13:0] yr_sel, n_u;
  logic [13:0] mul_a;
  logic [26:0] prod;
  logic [7:0]  quo;

  always_comb begin
    day_sel = cmd_i.side ? day_b_q   : day_a_q;
    mon_sel = cmd_i.side ? month_b_q : month_a_q;
    yr_sel  = cmd_i.side ? year_b_q  : year_a_q;
    n_u     = yr_sel - 14'd1;
    m_cl    = (mon_sel > 4'd11) ? 4'd11 : mon_sel;
  end

  // Shared divide-by-100 through a reciprocal multiply.
  always_comb begin
    case (cmd_i.op)
      OP_DIVQ:  mul_a = {2'b00, yr_sel[13:2]};
      OP_SQ100: mul_a = n_u;
      OP_SQ400: mul_a = {2'b00, n_u[13:2]};
      default:  mul_a = '0;
    endcase
    prod = 27'(mul_a) * 27'(RECIP_100);
    quo  = prod[RECIP_SHIFT +: 8];
  end

  // Day of year of the selected date.
  logic [8:0] start_m;
  logic       leap_y;
  logic [9:0] doy0;
  logic signed [17:0] yw;
  always_comb begin
    start_m = month_start(m_cl);
    leap_y  = leap_of(r400_q);
    doy0    = 10'(day_sel) + 10'(start_m) + 10'(leap_y && (m_cl >= 4'd2));
    yw      = $signed({4'b0000, yr_sel}) - $signed({17'd0, (doy0 == 10'd0)});
  end

  // Serial day number.
  logic [23:0] serial;
  always_comb begin
    if (yr_sel == 14'd0) begin
      serial = {{6{doy_q[17]}}, doy_q} - 24'd366;
    end else begin
      serial = 24'(n_u) * 24'd365 + 24'(n_u[13:2]) - 24'(q100_q) + 24'(q400_q)
             + {{6{doy_q[17]}}, doy_q};
    end
  end

  // One year step of the walk.
  logic signed [17:0] len_cur, len_dec;
  logic [8:0]         r_inc, r_dec;
  logic               over, under;
  always_comb begin
    r_inc   = (r_q == 9'd399) ? 9'd0 : r_q + 9'd1;
    r_dec   = (r_q == 9'd0) ? 9'd399 : r_q - 9'd1;
    len_cur = leap_of(r_q)   ? 18'sd366 : 18'sd365;
    len_dec = leap_of(r_dec) ? 18'sd366 : 18'sd365;
    over    = doy_q > len_cur;
    under   = doy_q <= 18'sd0;
  end

  assign status_o.mode      = mode_q;
  assign status_o.walk_done = !over && !under;

  // Month split of a walked date.
  logic [8:0]         doy9, st_m, dd;
  logic [3:0]         mo;
  logic signed [17:0] y18;
  logic               leap_r;
  always_comb begin
    doy9   = doy_q[8:0];
    leap_r = leap_of(r_q);
    y18    = {y_q[16], y_q};
    mo     = 4'd0;
    dd     = doy9;
    st_m   = '0;
    for (int m = 1; m < 12; m++) begin
      st_m = month_start(4'(m)) + 9'((m >= 2) && leap_r);
      if (doy9 > st_m) begin
        mo = 4'(m);
        dd = doy9 - st_m;
      end
    end
  end

  // Difference of the two serial days.
  logic [23:0] sdiff;
  always_comb begin
    if (sa_q > sb_q) sdiff = 24'(sa_q - sb_q);
    else             sdiff = 24'(sb_q - sa_q);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q    <= in_data_i[1:0];
        day_a_q   <= in_data_i[6:2];
        month_a_q <= in_data_i[10:7];
        year_a_q  <= in_data_i[24:11];
        day_b_q   <= in_data_i[29:25];
        month_b_q <= in_data_i[33:30];
        year_b_q  <= in_data_i[47:34];
        delta_q   <= in_data_i[63:48];
        oor_q     <= 1'b0;
      end
      OP_DIVQ:  qy_q <= quo;
      OP_DIVR:  r400_q <= 9'(yr_sel - 14'({6'd0, qy_q} * 14'd400));
      OP_DOY: begin
        r_q <= r400_q;
        y_q <= $signed({3'b000, yr_sel});
        if (mode_q == MODE_ADD)      doy_q <= $signed(18'(doy0) + 18'(delta_q));
        else if (mode_q == MODE_SUB) doy_q <= $signed(18'(doy0) - 18'(delta_q));
        else                         doy_q <= $signed(18'(doy0));
        if ((mode_q == MODE_DIFF) && ((yw < 18'sd1) || (yw > MaxY))) oor_q <= 1'b1;
      end
      OP_SQ100: q100_q <= quo;
      OP_SQ400: q400_q <= quo;
      OP_SER: begin
        if (cmd_i.side) sb_q <= $signed(serial);
        else            sa_q <= $signed(serial);
      end
      OP_WALK: begin
        if (over) begin
          doy_q <= doy_q - len_cur;
          y_q   <= y_q + 17'sd1;
          r_q   <= r_inc;
        end else if (under) begin
          doy_q <= doy_q + len_dec;
          y_q   <= y_q - 17'sd1;
          r_q   <= r_dec;
        end
      end
      OP_CMP: begin
        day_out_q   <= '0;
        month_out_q <= '0;
        year_out_q  <= '0;
        res_oor_q   <= oor_q;
        diff_q      <= (sdiff > 24'(DIFF_MAX)) ? DIFF_MAX : sdiff[21:0];
        if (sa_q < sb_q)      order_q <= ORD_BEFORE;
        else if (sa_q > sb_q) order_q <= ORD_AFTER;
        else                  order_q <= ORD_EQUAL;
      end
      OP_FIN: begin
        diff_q  <= '0;
        order_q <= ORD_EQUAL;
        if (y18 < 18'sd1) begin
          day_out_q   <= 5'd1;
          month_out_q <= 4'd0;
          year_out_q  <= 14'd1;
          res_oor_q   <= 1'b1;
        end else if (y18 > MaxY) begin
          day_out_q   <= 5'd31;
          month_out_q <= 4'd11;
          year_out_q  <= MaxY[13:0];
          res_oor_q   <= 1'b1;
        end else begin
          day_out_q   <= dd[4:0];
          month_out_q <= mo;
          year_out_q  <= y_q[13:0];
          res_oor_q   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_data_o = {res_oor_q, order_q, diff_q, year_out_q, month_out_q, day_out_q};

endmodule
`default_nettype wire
